/* hw/rtl/kfm_pkg.sv */
// Shared types and constants for the scalar Kalman residual marker.
// No dependencies; imported by every module of the block.
package kfm_pkg;

  localparam logic [47:0] Q_DEFAULT  = 48'd42950;
  localparam logic [47:0] R_DEFAULT  = 48'd4294967;
  localparam logic [47:0] VAR_ONE    = 48'h0001_0000_0000;
  localparam logic [15:0] MARKER_MAX = 16'd40960;
  localparam logic [5:0]  K_BITS     = 6'd32;
  localparam logic [5:0]  M_BITS     = 6'd48;
  localparam logic [5:0]  MUL_STEPS  = 6'd33;
  localparam logic [5:0]  SQRT_STEPS = 6'd32;

  typedef enum logic [0:0] {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_KSET,
    ST_DIVK,
    ST_MULD,
    ST_EST,
    ST_MULV,
    ST_VAR,
    ST_INN,
    ST_CHK,
    ST_SQRT,
    ST_MSET,
    ST_DIVM,
    ST_MARK,
    ST_OUT
  } state_t;

endpackage

/* hw/rtl/kfm_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on kfm_pkg for the step count.
module kfm_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] a,
  input  logic [32:0] b,
  output logic        done,
  output logic [80:0] prod
);
  import kfm_pkg::*;

  logic [47:0] a_reg;
  logic [32:0] mplier;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] sum;

  assign sum = {1'b0, prod[80:33]} + (mplier[0] ? {1'b0, a_reg} : 49'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_STEPS;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg  <= a;
      mplier <= b;
      prod   <= '0;
    end else if (busy) begin
      prod   <= {sum, prod[32:1]};
      mplier <= {1'b0, mplier[32:1]};
    end
  end

endmodule

/* hw/rtl/kfm_isqrt.sv */
// Digit-by-digit integer square root of a 64-bit value, two bits per cycle.
// Depends on kfm_pkg for the step count.
module kfm_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);
  import kfm_pkg::*;

  logic [63:0] vsh;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;

  assign rem_sh = {rem, vsh[63:62]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SQRT_STEPS;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vsh  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      root <= {root[30:0], ge};
      vsh  <= {vsh[61:0], 2'b00};
    end
  end

endmodule

/* hw/rtl/kalman_residual_marker_core.sv */
// Top level of the scalar Kalman residual marker.
// Depends on kfm_pkg, kfm_mul and kfm_isqrt.
//
// Usage:
// Configuration writes go through cfg_we, cfg_index and cfg_data while the
// block is idle; register 0 is the process noise Q and register 1 is the
// measurement noise R, both unsigned Q16.32, and zero selects the default.
// Each request on the slave stream carries a price and a seed price in
// s_tdata and the restart flag in s_tuser. It produces exactly one request
// on the master stream holding the marker size in Q4.12.
// The work is done by the bit-serial divider (32 steps for the gain, 48 for
// the marker), up to three passes of the serial multiplier of 33 steps each
// and the 32-step square root. A request with zero innovation or a
// saturated marker skips the late stages. One request is in work at a time.
// The finished result sits in an output register, and the next request is
// accepted while it waits for m_tready. Reset clears the estimate to zero,
// sets the variance to 1.0 and restores both noise registers to defaults.
module kalman_residual_marker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // price [31:0], seed_price [63:32]
  input  logic [0:0]  s_tuser,   // restart [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // marker_size [15:0]
);
  import kfm_pkg::*;

  state_t state, state_next;

  logic [47:0] q_reg, r_reg;
  logic [31:0] z, est;
  logic [47:0] var_reg, ppred;
  logic [48:0] div_rem, div_den;
  logic [47:0] div_num, quo;
  logic [5:0]  div_cnt;
  logic [15:0] mark;

  logic [47:0] q_eff, r_eff;
  logic [48:0] psum;
  logic        below;
  logic [31:0] diff;
  logic [49:0] rem_sh;
  logic        div_ge;
  logic [63:0] rnd;
  logic [31:0] delta;

  logic        mul_start, mul_done, sqrt_start, sqrt_done;
  logic [47:0] mul_a;
  logic [32:0] mul_b;
  logic [80:0] prod;
  logic [31:0] root;
  logic        out_load;

  assign q_eff  = (q_reg == '0) ? Q_DEFAULT : q_reg;
  assign r_eff  = (r_reg == '0) ? R_DEFAULT : r_reg;
  assign psum   = {1'b0, var_reg} + {1'b0, q_eff};
  assign below  = z < est;
  assign diff   = below ? est - z : z - est;
  assign rem_sh = {div_rem, div_num[47]};
  assign div_ge = rem_sh >= {1'b0, div_den};
  assign rnd    = prod[63:0] + 64'h0000_0000_8000_0000;
  assign delta  = rnd[63:32];

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  kfm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  kfm_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value ({var_reg, 16'h0000}),
    .done  (sqrt_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    mul_a      = {16'h0000, diff};
    mul_b      = {1'b0, quo[31:0]};
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_PRED;
        end
      end
      ST_PRED: state_next = ST_KSET;
      ST_KSET: state_next = ST_DIVK;
      ST_DIVK: begin
        if (div_cnt == 6'd1) begin
          state_next = ST_MULD;
        end
      end
      ST_MULD: begin
        mul_start  = 1'b1;
        state_next = ST_EST;
      end
      ST_EST: begin
        if (mul_done) begin
          state_next = ST_MULV;
        end
      end
      ST_MULV: begin
        mul_start  = 1'b1;
        mul_a      = ppred;
        mul_b      = 33'h1_0000_0000 - {1'b0, quo[31:0]};
        state_next = ST_VAR;
      end
      ST_VAR: begin
        if (mul_done) begin
          state_next = ST_INN;
        end
      end
      ST_INN: begin
        if (diff == '0 || diff[31:16] != '0) begin
          state_next = ST_OUT;
        end else begin
          mul_start  = 1'b1;
          mul_a      = {32'h0000_0000, diff[15:0]};
          mul_b      = {17'h00000, diff[15:0]};
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        if (mul_done) begin
          if ({prod[31:0], 16'h0000} >= var_reg) begin
            state_next = ST_OUT;
          end else begin
            sqrt_start = 1'b1;
            state_next = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          state_next = ST_MSET;
        end
      end
      ST_MSET: state_next = ST_DIVM;
      ST_DIVM: begin
        if (div_cnt == 6'd1) begin
          state_next = ST_MARK;
        end
      end
      ST_MARK: state_next = ST_OUT;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_reg   <= Q_DEFAULT;
      r_reg   <= R_DEFAULT;
      est     <= '0;
      var_reg <= VAR_ONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROCESS_NOISE:     q_reg <= cfg_data;
          REG_MEASUREMENT_NOISE: r_reg <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_IDLE && s_tvalid && s_tuser[0]) begin
        est     <= s_tdata[63:32];
        var_reg <= VAR_ONE;
      end
      if (state == ST_EST && mul_done) begin
        est <= below ? est - delta : est + delta;
      end
      if (state == ST_VAR && mul_done) begin
        var_reg <= prod[79:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        z <= s_tdata[31:0];
      end
      ST_PRED: begin
        ppred <= psum[48] ? {48{1'b1}} : psum[47:0];
      end
      ST_KSET: begin
        div_rem <= {1'b0, ppred};
        div_den <= {1'b0, ppred} + {1'b0, r_eff};
        div_num <= '0;
        div_cnt <= K_BITS;
      end
      ST_INN: begin
        mark <= (diff == '0) ? 16'h0000 : MARKER_MAX;
      end
      ST_CHK: begin
        mark <= MARKER_MAX;
      end
      ST_MSET: begin
        div_rem <= '0;
        div_den <= {17'h00000, root};
        div_num <= {({4'h0, diff[15:0]} << 3) + ({4'h0, diff[15:0]} << 1), 28'h0000000};
        div_cnt <= M_BITS;
      end
      ST_MARK: begin
        mark <= (quo > {32'h0000_0000, MARKER_MAX}) ? MARKER_MAX : quo[15:0];
      end
      default: ;
    endcase
    if (state == ST_DIVK || state == ST_DIVM) begin
      div_rem <= div_ge ? 49'(rem_sh - {1'b0, div_den}) : rem_sh[48:0];
      div_num <= {div_num[46:0], 1'b0};
      quo     <= {quo[46:0], div_ge};
      div_cnt <= div_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= mark;
    end
  end

endmodule

/* verif/kalman_residual_marker_checker.sv */
// Checker for the scalar Kalman residual marker: watches the register port and
// both streams, predicts every marker size and compares it. Depends on kfm_pkg.
`timescale 1ns / 100ps

module kalman_residual_marker_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  output int          errors,
  output int          pending
);
  import kfm_pkg::*;

  bit [47:0] noise_q;
  bit [47:0] noise_r;
  bit [31:0] est_price;
  bit [47:0] est_var;
  bit [15:0] marker_queue[$];

  function automatic bit [63:0] root64(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Advances the filter by one sample and returns the expected marker size.
  function automatic bit [15:0] filter_step(bit [31:0] price, bit restart, bit [31:0] seed);
    bit [63:0] q, r, ppred, den, rem, gain, diff, delta, m, inn, mk, s, est;
    q = (noise_q != 0) ? 64'(noise_q) : 64'(Q_DEFAULT);
    r = (noise_r != 0) ? 64'(noise_r) : 64'(R_DEFAULT);
    if (restart) begin
      est_price = seed;
      est_var = VAR_ONE;
    end
    ppred = 64'(est_var) + q;
    if (ppred > 64'hFFFF_FFFF_FFFF) ppred = 64'hFFFF_FFFF_FFFF;
    den = ppred + r;
    rem = ppred;
    gain = 0;
    for (int i = 0; i < 32; i++) begin
      rem <<= 1;
      gain <<= 1;
      if (rem >= den) begin
        rem -= den;
        gain |= 64'd1;
      end
    end
    est = 64'(est_price);
    if (64'(price) >= est) begin
      diff = 64'(price) - est;
      delta = (gain * diff + (64'd1 << 31)) >> 32;
      est += delta;
    end else begin
      diff = est - 64'(price);
      delta = (gain * diff + (64'd1 << 31)) >> 32;
      est -= delta;
    end
    est_price = est[31:0];
    m = (64'd1 << 32) - gain;
    est_var = 48'((ppred >> 32) * m + (((ppred & 64'hFFFF_FFFF) * m) >> 32));
    inn = (price >= est_price) ? 64'(price - est_price) : 64'(est_price - price);
    if (inn == 0) begin
      mk = 0;
    end else if (inn >= (64'd1 << 16) || inn * inn * (64'd1 << 16) >= 64'(est_var)) begin
      mk = 64'(MARKER_MAX);
    end else begin
      s = root64(64'(est_var) << 16);
      mk = (s != 0) ? ((64'd10 * inn) << 28) / s : 64'(MARKER_MAX);
      if (mk > 64'(MARKER_MAX)) mk = 64'(MARKER_MAX);
    end
    return mk[15:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      noise_q <= Q_DEFAULT;
      noise_r <= R_DEFAULT;
      est_price <= '0;
      est_var <= VAR_ONE;
      marker_queue.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PROCESS_NOISE) noise_q <= cfg_data;
        else noise_r <= cfg_data;
      end
      if (s_tvalid && s_tready)
        marker_queue.push_back(filter_step(s_tdata[31:0], s_tuser[0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        if (marker_queue.size() == 0) begin
          $display("%0t: unexpected marker_size, expected none, actual %0d", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          bit [15:0] want;
          want = marker_queue.pop_front();
          if (want != m_tdata) begin
            $display("%0t: marker_size mismatch, expected %0d, actual %0d",
                     $time, want, m_tdata);
            errors <= errors + 1;
          end
        end
      end
      pending <= marker_queue.size();
    end
  end

endmodule

/* verif/kalman_residual_marker_core_test.sv */
// Testbench top for the scalar Kalman residual marker: clock, reset, register
// writes and stream stimulus. Depends on kfm_pkg, the block and the checker.
`timescale 1ns / 100ps

module kalman_residual_marker_core_test;
  import kfm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_PROCESS_NOISE;
  logic [47:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // price [31:0], seed_price [63:32]
  logic [0:0]  s_tuser = '0;   // restart [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // marker_size [15:0]
  int          errors;
  int          pending;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          cycles = 0;
  bit [31:0]   last_price = 32'h0000_6400;

  always #4 clk = ~clk;

  kalman_residual_marker_core dut (.*);

  kalman_residual_marker_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random ready bursts, one long hold-off on request.
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 12);
        m_tready <= $urandom_range(0, 1);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_request(bit [31:0] price, bit restart, bit [31:0] seed);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {seed, price};
    s_tuser <= restart;
    do @(posedge clk); while (!s_tready);
    gap = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_noise(cfg_reg_t idx, bit [47:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    bit [31:0] p;
    bit [31:0] seed;
    bit restart;
    restart = ($urandom_range(0, 19) == 0);
    seed = ($urandom_range(0, 3) == 0) ? $urandom : last_price;
    if ($urandom_range(0, 9) == 0) p = $urandom;
    else p = (restart ? seed : last_price) + $urandom_range(0, 2047) - 1024;
    last_price = p;
    send_request(p, restart, seed);
  endtask

  initial begin
    bit [47:0] qs[5];
    bit [47:0] rs[5];
    qs = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd42950, 48'd0};
    rs = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd4294967, 48'd0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset noise values.
    send_request(32'd0, 1'b0, 32'd0);
    send_request(32'hFFFF_FFFF, 1'b0, 32'd0);
    send_request(32'd0, 1'b1, 32'hFFFF_FFFF);
    send_request(32'h1234_5678, 1'b1, 32'h1234_5678);
    send_request(32'h1234_5678, 1'b0, 32'd0);
    send_request(32'h1234_5679, 1'b0, 32'd0);
    send_request(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_request(32'h0000_0100, 1'b1, 32'h0000_0000);
    write_noise(REG_PROCESS_NOISE, 48'd1);
    write_noise(REG_MEASUREMENT_NOISE, 48'd1);
    for (int i = 0; i < 6; i++) send_request(32'h0000_0200 + i, 1'b0, 32'd0);
    write_noise(REG_PROCESS_NOISE, 48'hFFFF_FFFF_FFFF);
    write_noise(REG_MEASUREMENT_NOISE, 48'hFFFF_FFFF_FFFF);
    send_request(32'h0000_0300, 1'b1, 32'h0000_0100);
    send_request(32'hAAAA_5555, 1'b0, 32'h5555_AAAA);
    send_request(32'h5555_AAAA, 1'b0, 32'hAAAA_5555);

    // Random phases across noise settings; one long receiver hold-off.
    for (int ph = 0; ph < 6; ph++) begin
      write_noise(REG_PROCESS_NOISE, (ph < 5) ? qs[ph] : 48'($urandom_range(0, 1000000)));
      write_noise(REG_MEASUREMENT_NOISE,
                  (ph < 5) ? rs[ph] : {16'($urandom), 32'($urandom)});
      if (ph == 1) hold_req = 1'b1;
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 300; i++) random_request();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/kfm_pkg.sv
hw/rtl/kfm_mul.sv
hw/rtl/kfm_isqrt.sv
hw/rtl/kalman_residual_marker_core.sv
verif/kalman_residual_marker_checker.sv
verif/kalman_residual_marker_core_test.sv
